[hdl/bpb_pkg.sv]
// Package for the branch predictor with target buffer.
// Holds table sizes, register and mode codes and the shared types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpb_pkg;

   localparam int ADDR_BITS      = 48;
   localparam int INDEX_BITS     = 12;
   localparam int HIST_BITS      = 16;
   localparam int TABLE_DEPTH    = 1 << INDEX_BITS;
   localparam int CLEAR_CNT_BITS = INDEX_BITS + 1;
   localparam int PC_INDEX_LSB   = 3;
   localparam int FIFO_DEPTH     = 3;
   localparam int FIFO_PTR_BITS  = 2;
   localparam int FIFO_CNT_BITS  = 2;

   localparam logic [1:0] CTR_RESET      = 2'd1;
   localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
   localparam logic [1:0] CTR_MAX        = 2'd3;
   localparam logic [1:0] CTR_MIN        = 2'd0;

   localparam logic [ADDR_BITS-1:0] PC_STEP = ADDR_BITS'(4);

   typedef enum logic [1:0] {
      CSR_MODE         = 2'd0,
      CSR_INDEX_BITS   = 2'd1,
      CSR_HISTORY_BITS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_BIMODAL = 2'd0,
      MODE_GSHARE  = 2'd1,
      MODE_GSELECT = 2'd2
   } mode_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] target;
      logic [1:0]           ctr;
   } entry_type;

   typedef struct packed {
      logic [FIFO_CNT_BITS-1:0] count;
      logic                     empty;
   } fifo_status_type;

endpackage

`default_nettype wire

[hdl/branch_predictor_btb.sv]
// Branch predictor with target buffer: top level, table memory and update stage.
// Depends on bpb_pkg, bpb_index and bpb_rsp_fifo.
// Result path: an accepted item passes the update stage and the result queue before rsp_tvalid rises.
// Throughput: one item per cycle while req_tready is high; table read at accept, written back
//   from the update stage, with one-entry forwarding for back-to-back items on the same entry.
// Reset: synchronous; then a clearing pass over all 4096 entries, one table entry a cycle,
//   with req_tready low. Register writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module branch_predictor_btb import bpb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [4:0]             csr_wdata,
   // branch items in
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [2*ADDR_BITS-1:0] req_tdata,  // pc_address [47:0], next_pc [95:48]
   // predictions out
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [ADDR_BITS-1:0]   rsp_tdata   // predicted_pc [47:0]
);

   // ---- configuration registers ----
   logic [1:0] mode_ff;
   logic [3:0] index_bits_ff;
   logic [4:0] history_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_BIMODAL;
         index_bits_ff   <= 4'(INDEX_BITS);
         history_bits_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:         mode_ff         <= csr_wdata[1:0];
            CSR_INDEX_BITS:   index_bits_ff   <= csr_wdata[3:0];
            CSR_HISTORY_BITS: history_bits_ff <= csr_wdata;
            default: ;        // unused index, write dropped
         endcase
      end
   end

   // ---- clearing pass ----
   logic [CLEAR_CNT_BITS-1:0] clear_cnt_ff, clear_cnt_in;
   logic                      clear_done;

   assign clear_done   = clear_cnt_ff[CLEAR_CNT_BITS-1];
   assign clear_cnt_in = clear_done ? clear_cnt_ff : clear_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) clear_cnt_ff <= '0;
      else       clear_cnt_ff <= clear_cnt_in;
   end

   // ---- accept stage: index, outcome and history ----
   logic [ADDR_BITS-1:0]  req_pc, req_next, req_fall;
   logic                  req_taken;
   logic                  req_fire;
   logic [INDEX_BITS-1:0] req_idx;
   logic [HIST_BITS-1:0]  history_ff, history_in;
   logic [4:0]            hist_len;

   assign req_pc    = req_tdata[ADDR_BITS-1:0];
   assign req_next  = req_tdata[2*ADDR_BITS-1:ADDR_BITS];
   assign req_fall  = req_pc + PC_STEP;          // wraps at the address width
   assign req_taken = (req_next != req_fall);
   assign req_fire  = req_tvalid && req_tready;

   bpb_index u_index (
      .mode         (mode_ff),
      .index_bits   (index_bits_ff),
      .history_bits (history_bits_ff),
      .pc_bits      (req_pc[PC_INDEX_LSB +: INDEX_BITS]),
      .history      (history_ff),
      .index        (req_idx)
   );

   // history length clipped at the register width
   assign hist_len = (history_bits_ff > 5'(HIST_BITS)) ? 5'(HIST_BITS) : history_bits_ff;

   always_comb begin
      history_in = history_ff;
      if (req_fire && hist_len != '0) begin
         history_in = {history_ff[HIST_BITS-2:0], req_taken} & ~({HIST_BITS{1'b1}} << hist_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) history_ff <= '0;
      else       history_ff <= history_in;
   end

   // ---- table memory: counter and target per entry ----
   entry_type             table_mem [TABLE_DEPTH];
   entry_type             rd_data_ff;
   logic                  tbl_we;
   logic [INDEX_BITS-1:0] tbl_waddr;
   entry_type             tbl_wdata;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_waddr] <= tbl_wdata;
      end
      rd_data_ff <= table_mem[req_idx];
   end

   // ---- update stage ----
   logic                  s1_valid_ff, s1_valid_in;
   logic [INDEX_BITS-1:0] s1_idx_ff;
   logic [ADDR_BITS-1:0]  s1_fall_ff;
   logic [ADDR_BITS-1:0]  s1_next_ff;
   logic                  s1_taken_ff;
   logic                  fwd_hit_ff, fwd_hit_in;
   entry_type             fwd_data_ff;
   entry_type             cur;
   entry_type             upd;
   logic [ADDR_BITS-1:0]  s1_pred;

   assign s1_valid_in = req_fire;

   always_comb begin
      // entry written by the item just ahead is not yet in the memory read
      cur = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      s1_pred = (cur.ctr >= CTR_WEAK_TAKEN && cur.target != '0) ? cur.target : s1_fall_ff;
      upd = cur;
      if (s1_taken_ff) begin
         upd.target = s1_next_ff;
         if (cur.ctr != CTR_MAX) upd.ctr = cur.ctr + 1'b1;
      end else begin
         if (cur.ctr != CTR_MIN) upd.ctr = cur.ctr - 1'b1;
      end
      fwd_hit_in = req_fire && s1_valid_ff && (s1_idx_ff == req_idx);
   end

   always_comb begin
      if (!clear_done) begin
         tbl_we           = 1'b1;
         tbl_waddr        = clear_cnt_ff[INDEX_BITS-1:0];
         tbl_wdata.target = '0;
         tbl_wdata.ctr    = CTR_RESET;
      end else begin
         tbl_we    = s1_valid_ff;
         tbl_waddr = s1_idx_ff;
         tbl_wdata = upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_idx_ff   <= req_idx;
         s1_fall_ff  <= req_fall;
         s1_next_ff  <= req_next;
         s1_taken_ff <= req_taken;
         fwd_data_ff <= upd;
      end
   end

   // ---- result queue ----
   fifo_status_type      fifo_status;
   logic [ADDR_BITS-1:0] fifo_head;
   logic [2:0]           in_flight;

   bpb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_pred),
      .pop       (rsp_tready),
      .head_data (fifo_head),
      .status    (fifo_status)
   );

   // queued items plus the one in the update stage must leave room for one more
   assign in_flight  = {1'b0, fifo_status.count} + {2'b00, s1_valid_ff};
   assign req_tready = clear_done && (in_flight < 3'(FIFO_DEPTH));
   assign rsp_tvalid = !fifo_status.empty;
   assign rsp_tdata  = fifo_head;

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> clear_done)
      else $error("item accepted during table clearing");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (fifo_status.count != 2'd3))
      else $error("result queue overflow");

   a_fwd_follows_update: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> (s1_valid_ff && $past(s1_valid_ff)))
      else $error("forwarding without a preceding update");

   a_stage_from_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item lost before update stage");
`endif

endmodule

`default_nettype wire

[hdl/bpb_index.sv]
// Table index generation: bimodal, gshare and gselect.
// Depends on bpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpb_index import bpb_pkg::*; (
   input  wire logic [1:0]            mode,
   input  wire logic [3:0]            index_bits,
   input  wire logic [4:0]            history_bits,
   input  wire logic [INDEX_BITS-1:0] pc_bits,
   input  wire logic [HIST_BITS-1:0]  history,
   output logic      [INDEX_BITS-1:0] index
);

   logic [3:0]            s;
   logic [3:0]            b;
   logic                  b_lt_s;
   logic [3:0]            low_bits;
   logic [INDEX_BITS-1:0] imask;
   logic [INDEX_BITS-1:0] base;
   logic [INDEX_BITS-1:0] hist_low;
   logic [INDEX_BITS-1:0] sel_idx;

   always_comb begin
      s = (index_bits > 4'(INDEX_BITS)) ? 4'(INDEX_BITS) : index_bits;
      // history longer than any index never takes the gselect path, so clip to 4 bits
      b_lt_s = ({1'b0, s} > history_bits);
      b = history_bits[3:0];
      low_bits = s - b;
      imask = ~({INDEX_BITS{1'b1}} << s);
      base = pc_bits & imask;
      hist_low = history[INDEX_BITS-1:0] & ~({INDEX_BITS{1'b1}} << b);
      sel_idx = ((base & ~({INDEX_BITS{1'b1}} << low_bits)) | (hist_low << low_bits)) & imask;
      case (mode)
         MODE_GSHARE:  index = (base ^ history[INDEX_BITS-1:0]) & imask;
         MODE_GSELECT: index = b_lt_s ? sel_idx : base;
         default:      index = base;
      endcase
   end

endmodule

`default_nettype wire

[hdl/bpb_rsp_fifo.sv]
// Three-entry result queue between the update stage and the result channel.
// Depends on bpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpb_rsp_fifo import bpb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [ADDR_BITS-1:0] push_data,
   input  wire logic                 pop,
   output logic      [ADDR_BITS-1:0] head_data,
   output fifo_status_type           status
);

   logic [ADDR_BITS-1:0]     slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_pop;

   always_comb begin
      do_pop = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire
